// File: hdl/tbl_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket limiter package
// Shared constants, widths, codes and interface structs.
// ----------------------------------------------------------------------------
package tbl_pkg;

	// Saturation limits of the rate and burst registers
	localparam longint unsigned MAX_RATE  = 64'd1000000;
	localparam longint unsigned MAX_BURST = 64'd1000000;

	// Micro-tokens per whole token, milliseconds per second
	localparam longint unsigned FP_ONE   = 64'd1000000;
	localparam longint unsigned MS_PER_S = 64'd1000;

	// Port widths
	localparam int TIME_W    = 64;
	localparam int COST_W    = 32;
	localparam int REG32_W   = 32;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	// Internal widths
	localparam int RATE_W  = $clog2(MAX_RATE + 64'd1);
	localparam int BURST_W = $clog2(MAX_BURST + 64'd1);
	localparam int LEVEL_W = $clog2(MAX_BURST * FP_ONE + 64'd1);
	localparam int RK_W    = $clog2(MAX_RATE * MS_PER_S + 64'd1);
	localparam int NEED_W  = $clog2(((64'd1 << COST_W) - 64'd1) * FP_ONE + 64'd1);
	localparam int ACC_W   = ((LEVEL_W > RK_W) ? LEVEL_W : RK_W) + 2;
	localparam int CNT_W   = $clog2(TIME_W + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START = 2'd2;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_REFILL,
		ST_CHECK
	} tbl_state_t;

	// How a request is handled
	typedef enum logic [1:0] {
		KIND_FREE,
		KIND_DENY,
		KIND_REFILL,
		KIND_TAKE
	} tbl_kind_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic               reload;
		logic               enabled;
		logic [RK_W-1:0]    rate_k;
		logic [LEVEL_W-1:0] cap;
		logic [TIME_W-1:0]  start;
	} tbl_cfg_t;

	// Result of the serial refill multiplier
	typedef struct packed {
		logic               done;
		logic               fill;
		logic [LEVEL_W-1:0] gain;
	} tbl_mul_t;

endpackage

// File: hdl/token_bucket_limiter.sv
// Token bucket rate limiter in micro-tokens (one token = 1000000). A request
// whose time has moved past the last refill is latched on its transfer, then
// passes the serial multiplier, which steps through the 64 bits of the elapsed
// time, then a refill state and a decision state before its result is ready. A
// request with zero cost, a disabled bucket or no time advance skips the
// multiplier and goes straight to the decision. One request is in work at a time;
// the next one may be taken while the previous result waits in the output
// register. Each write to a used configuration index reloads the bucket on the
// following cycle, during which no request is taken.
// ----------------------------------------------------------------------------
// Token bucket limiter top level
// Request sequencer, bucket state and output register.
// ----------------------------------------------------------------------------
module token_bucket_limiter import tbl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [COST_W-1:0]    request_cost,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 allowed,
	output logic [TIME_W-1:0]    tokens_left_fp
);

	tbl_cfg_t           cfg;
	tbl_mul_t           mul;

	tbl_state_t         state_q;
	tbl_state_t         state_d;
	tbl_kind_t          kind_q;
	tbl_kind_t          kind_d;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  now_q;
	logic [NEED_W-1:0]  need_q;
	logic               out_valid_q;
	logic               allowed_q;
	logic [LEVEL_W-1:0] left_q;

	logic               in_xfer;
	logic               slot_free;
	logic               mul_start;
	logic               out_load;
	logic [TIME_W-1:0]  elapsed;
	logic [LEVEL_W-1:0] missing;
	logic               take_ok;
	logic [LEVEL_W-1:0] level_sub;
	logic               allowed_d;

	tbl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tbl_sermul u_sermul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.elapsed (elapsed),
		.rate_k  (cfg.rate_k),
		.missing (missing),
		.res     (mul)
	);

	// Classify the incoming request
	always_comb begin
		elapsed = now_ms - last_q;
		missing = cfg.cap - level_q;
		priority if (request_cost == '0) begin
			kind_d = KIND_FREE;
		end else if (!cfg.enabled) begin
			kind_d = KIND_DENY;
		end else if (now_ms > last_q) begin
			kind_d = KIND_REFILL;
		end else begin
			kind_d = KIND_TAKE;
		end
	end

	// Decide on the request against the current level
	always_comb begin
		take_ok   = {{(NEED_W - LEVEL_W){1'b0}}, level_q} >= need_q;
		level_sub = level_q - need_q[LEVEL_W-1:0];
		unique case (kind_q)
			KIND_FREE: allowed_d = 1'b1;
			KIND_DENY: allowed_d = 1'b0;
			default:   allowed_d = take_ok;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (kind_d == KIND_REFILL) ? ST_MUL : ST_CHECK;
				end
			end
			ST_MUL: begin
				if (mul.done) begin
					state_d = ST_REFILL;
				end
			end
			ST_REFILL: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		slot_free = !out_valid_q || out_ready;
		in_ready  = (state_q == ST_IDLE) && !cfg.reload;
		in_xfer   = in_valid && in_ready;
		mul_start = in_xfer && (kind_d == KIND_REFILL);
		out_load  = (state_q == ST_CHECK) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= kind_d;
			now_q  <= now_ms;
			need_q <= NEED_W'(64'(request_cost) * FP_ONE);
		end
	end

	// Bucket state: reload on configuration, refill, then take tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			last_q  <= '0;
		end else if (cfg.reload) begin
			level_q <= cfg.cap;
			last_q  <= cfg.start;
		end else if (state_q == ST_REFILL) begin
			level_q <= mul.fill ? cfg.cap : level_q + mul.gain;
			last_q  <= now_q;
		end else if (out_load && (kind_q == KIND_REFILL || kind_q == KIND_TAKE) && take_ok) begin
			level_q <= level_sub;
		end
	end

	// Output register: hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			allowed_q <= allowed_d;
			left_q    <= ((kind_q == KIND_REFILL || kind_q == KIND_TAKE) && take_ok)
				? level_sub : level_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign allowed        = allowed_q;
	assign tokens_left_fp = TIME_W'(left_q);

endmodule

// File: hdl/tbl_cfg.sv
// ----------------------------------------------------------------------------
// Token bucket limiter configuration registers
// Saturates rate and burst on write and keeps the derived refill step and
// bucket capacity; flags a bucket reload in the cycle after any valid write.
// ----------------------------------------------------------------------------
module tbl_cfg import tbl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output tbl_cfg_t             cfg
);

	logic [RK_W-1:0]    rate_k_q;
	logic [LEVEL_W-1:0] cap_q;
	logic [TIME_W-1:0]  start_q;
	logic               reload_q;

	logic [REG32_W-1:0] wdata32;
	logic [RATE_W-1:0]  rate_sat;
	logic [BURST_W-1:0] burst_sat;

	// Clamp written values to their limits
	always_comb begin
		wdata32   = cfg_wdata[REG32_W-1:0];
		rate_sat  = (64'(wdata32) > MAX_RATE) ? RATE_W'(MAX_RATE) : RATE_W'(wdata32);
		burst_sat = (64'(wdata32) > MAX_BURST) ? BURST_W'(MAX_BURST) : BURST_W'(wdata32);
	end

	// Register writes; rate kept as micro-tokens per millisecond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_k_q <= '0;
			cap_q    <= '0;
			start_q  <= '0;
			reload_q <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RATE: begin
						rate_k_q <= RK_W'(64'(rate_sat) * MS_PER_S);
						reload_q <= 1'b1;
					end
					REG_BURST: begin
						cap_q    <= LEVEL_W'(64'(burst_sat) * FP_ONE);
						reload_q <= 1'b1;
					end
					REG_START: begin
						start_q  <= cfg_wdata[TIME_W-1:0];
						reload_q <= 1'b1;
					end
					default: begin
						reload_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// Present configuration
	always_comb begin
		cfg.reload  = reload_q;
		cfg.enabled = (rate_k_q != '0) && (cap_q != '0);
		cfg.rate_k  = rate_k_q;
		cfg.cap     = cap_q;
		cfg.start   = start_q;
	end

endmodule

// File: hdl/tbl_sermul.sv
// ----------------------------------------------------------------------------
// Token bucket limiter serial refill multiplier
// Forms elapsed time times the per-millisecond refill step one bit of the
// elapsed time per cycle, most significant bit first, and stops growing once
// the product passes the missing amount.
// ----------------------------------------------------------------------------
module tbl_sermul import tbl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TIME_W-1:0]  elapsed,
	input  logic [RK_W-1:0]    rate_k,
	input  logic [LEVEL_W-1:0] missing,
	output tbl_mul_t           res
);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  shift_q;
	logic [RK_W-1:0]    rk_q;
	logic [LEVEL_W-1:0] miss_q;
	logic [ACC_W-1:0]   acc_q;
	logic               over_q;

	logic [ACC_W-1:0]   acc_n;

	// Double and add the step for the current time bit; acc is only updated
	// while at or below the missing amount, so the dropped top bit is zero whenever acc_n is taken
	always_comb begin
		acc_n = {acc_q[ACC_W-2:0], 1'b0} + (shift_q[TIME_W-1] ? ACC_W'(rk_q) : ACC_W'(0));
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= elapsed;
			rk_q    <= rate_k;
			miss_q  <= missing;
			acc_q   <= '0;
			over_q  <= 1'b0;
		end else if (busy_q) begin
			shift_q <= {shift_q[TIME_W-2:0], 1'b0};
			if (!over_q) begin
				acc_q  <= acc_n;
				over_q <= acc_n > ACC_W'(miss_q);
			end
		end
	end

	// Bucket fills when the product reaches the missing amount
	always_comb begin
		res.done = done_q;
		res.fill = over_q || (acc_q == ACC_W'(miss_q));
		res.gain = acc_q[LEVEL_W-1:0];
	end

endmodule

// File: tb/sv/token_bucket_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket limiter testbench
// Drives a short scripted sequence, then random phases of register settings
// and requests, idles both channels at random, and checks every verdict and
// token count against a behavioral bucket model or a scripted expectation.
// ----------------------------------------------------------------------------
module token_bucket_limiter_tb;
	import tbl_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int RANDOM_REQUESTS = 2000;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int TAIL_CYCLES     = 100;
	localparam int STEADY_FIRST    = 600;
	localparam int STEADY_LAST     = 900;

	// Index past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0]    TIME_MAX   = '1;

	typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

	typedef struct packed {
		logic              ok;
		logic [TIME_W-1:0] left;
	} verdict_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [TIME_W-1:0]    now;
		logic [COST_W-1:0]    cost;
		logic                 known;
		verdict_t             want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [TIME_W-1:0]    now_ms;
	logic [COST_W-1:0]    request_cost;
	logic                 out_valid;
	logic                 out_ready;
	logic                 allowed;
	logic [TIME_W-1:0]    tokens_left_fp;

	// Model of the bucket and its registers
	logic [63:0] mdl_rate;
	logic [63:0] mdl_burst;
	logic [63:0] mdl_start;
	logic [63:0] mdl_level;
	logic [63:0] mdl_last;

	verdict_t    pending_verdicts[$];
	script_row_t script[$];

	logic steady;
	int   mismatches;
	int   requests_sent;
	int   verdicts_seen;
	int   granted;
	int   reg_writes;
	int   cycles;

	token_bucket_limiter u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.now_ms         (now_ms),
		.request_cost   (request_cost),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.allowed        (allowed),
		.tokens_left_fp (tokens_left_fp)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Bucket model
	// ------------------------------------------------------------------

	// Saturate a 64x64 product at all ones
	function automatic logic [63:0] sat_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return (p[127:64] != 64'd0) ? '1 : p[63:0];
	endfunction

	function automatic void reload_bucket();
		mdl_level = sat_product(mdl_burst, FP_ONE);
		mdl_last  = mdl_start;
	endfunction

	// Apply a register write; an unused index leaves everything alone
	function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		logic [63:0] low;
		low = {32'd0, data[31:0]};
		case (idx)
			REG_RATE: begin
				mdl_rate = (low > MAX_RATE) ? MAX_RATE : low;
				reload_bucket();
			end
			REG_BURST: begin
				mdl_burst = (low > MAX_BURST) ? MAX_BURST : low;
				reload_bucket();
			end
			REG_START: begin
				mdl_start = data;
				reload_bucket();
			end
			default: begin
			end
		endcase
	endfunction

	// Credit tokens for the time elapsed since the last refill
	function automatic void refill_bucket(input logic [63:0] now);
		logic [63:0] cap;
		logic [63:0] per_s;
		logic [63:0] missing;
		logic [63:0] num;
		logic [63:0] fill_ms;
		logic [63:0] elapsed;
		logic [63:0] gain;
		if (mdl_rate == 64'd0 || now <= mdl_last)
			return;
		cap = sat_product(mdl_burst, FP_ONE);
		if (mdl_level >= cap) begin
			mdl_level = cap;
			mdl_last  = now;
			return;
		end
		elapsed = now - mdl_last;
		per_s   = sat_product(mdl_rate, FP_ONE);
		missing = cap - mdl_level;
		num     = sat_product(missing, MS_PER_S);
		fill_ms = num / per_s;
		if (num % per_s != 64'd0)
			fill_ms = fill_ms + 64'd1;
		if (elapsed >= fill_ms) begin
			mdl_level = cap;
		end else begin
			gain      = sat_product(elapsed, per_s) / MS_PER_S;
			mdl_level = (gain >= missing) ? cap : mdl_level + gain;
		end
		mdl_last = now;
	endfunction

	// Verdict and remaining tokens for one request
	function automatic verdict_t charge_bucket(input logic [63:0] now,
			input logic [COST_W-1:0] cost);
		verdict_t    v;
		logic [63:0] need;
		v.ok = 1'b0;
		if (cost == '0) begin
			v.ok = 1'b1;
		end else if (mdl_rate != 64'd0 && mdl_burst != 64'd0) begin
			refill_bucket(now);
			need = sat_product({32'd0, cost}, FP_ONE);
			if (need <= mdl_level) begin
				mdl_level = mdl_level - need;
				v.ok      = 1'b1;
			end
		end
		v.left = mdl_level;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Script rows
	// ------------------------------------------------------------------

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		script_row_t r;
		r.kind  = ROW_WRITE;
		r.idx   = idx;
		r.data  = data;
		r.now   = '0;
		r.cost  = '0;
		r.known = 1'b0;
		r.want  = '0;
		script.push_back(r);
	endfunction

	function automatic void add_request(input logic [63:0] now, input logic [COST_W-1:0] cost,
			input logic known = 1'b0, input logic ok = 1'b0, input logic [63:0] left = '0);
		script_row_t r;
		r.kind    = ROW_REQUEST;
		r.idx     = REG_UNUSED;
		r.data    = '0;
		r.now     = now;
		r.cost    = cost;
		r.known   = known;
		r.want.ok = ok;
		r.want.left = left;
		script.push_back(r);
	endfunction

	// Register and rate values: zero, one, small, in range, all ones, any word
	function automatic logic [63:0] pick_count_word();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return 64'd1;
			2: return 64'($urandom_range(1, 20));
			3: return 64'($urandom_range(1, 1000));
			4: return 64'($urandom_range(1, 32'(MAX_RATE)));
			5: return 64'h0000_0000_FFFF_FFFF;
			6: return {$urandom, $urandom};
			default: return 64'($urandom_range(1, 100000));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Drop valid and wait until every verdict has come back
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		drain_pipeline();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		model_write(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the request until its transfer, then queue the verdict
	task automatic send_request(input logic [63:0] now, input logic [COST_W-1:0] cost,
			input logic known, input verdict_t want);
		verdict_t v;
		@(negedge clk);
		in_valid     <= 1'b1;
		now_ms       <= now;
		request_cost <= cost;
		do
			@(posedge clk);
		while (!in_ready);
		v = charge_bucket(now, cost);
		pending_verdicts.push_back(known ? want : v);
		requests_sent++;
	endtask

	// Idle the sender now and then, sometimes long, sometimes until drained
	task automatic maybe_pause();
		int n;
		if (steady)
			return;
		if ($urandom_range(0, 99) < 15) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		if ($urandom_range(0, 79) == 0)
			drain_pipeline();
	endtask

	// ------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------

	// Stall the result channel at random outside the steady stretch
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 15);
	end

	// Compare each result transfer with the oldest pending verdict
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("result with nothing pending", tokens_left_fp, '0);
			end else begin
				want = pending_verdicts.pop_front();
				if (allowed !== want.ok)
					flag_mismatch("allowed", 64'(allowed), 64'(want.ok));
				if (tokens_left_fp !== want.left)
					flag_mismatch("tokens_left_fp", tokens_left_fp, want.left);
				verdicts_seen++;
				if (allowed === 1'b1)
					granted++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit %0d hit, %0d verdicts pending", CYCLE_LIMIT,
				pending_verdicts.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [63:0]          t_now;
		logic [63:0]          now;
		logic [63:0]          span;
		logic [63:0]          dt;
		logic [COST_W-1:0]    cost;
		logic [CFG_IDX_W-1:0] idx;
		logic [2:0]           mask;
		int                   first;
		int                   mode;
		int                   phase_left;
		int                   random_sent;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		now_ms        = '0;
		request_cost  = '0;
		out_ready     = 1'b0;
		steady        = 1'b0;
		mismatches    = 0;
		requests_sent = 0;
		verdicts_seen = 0;
		granted       = 0;
		reg_writes    = 0;
		cycles        = 0;
		random_sent   = 0;
		mdl_rate      = '0;
		mdl_burst     = '0;
		mdl_start     = '0;
		reload_bucket();

		// Hold reset, release between edges
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Zero cost passes and zero rate denies right after reset
		add_request(64'd5, 32'd0, 1'b1, 1'b1, 64'd0);
		add_request(64'd10, 32'd1, 1'b1, 1'b0, 64'd0);
		add_request(64'd7, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'd0);
		// Rate set but burst still zero: deny
		add_write(REG_RATE, 64'd10);
		add_request(64'd50, 32'd1, 1'b1, 1'b0, 64'd0);
		add_write(REG_BURST, 64'd5);
		add_write(REG_START, 64'd100);
		// Same time, earlier time, zero cost: no refill
		add_request(64'd100, 32'd1, 1'b1, 1'b1, 64'd4000000);
		add_request(64'd50, 32'd5, 1'b1, 1'b0, 64'd4000000);
		add_request(64'd150, 32'd0, 1'b1, 1'b1, 64'd4000000);
		// Exact fill time, partial gain, largest time and cost, full bucket
		add_request(64'd200, 32'd2);
		add_request(64'd201, 32'd1);
		add_request(TIME_MAX, 32'hFFFF_FFFF);
		add_request(TIME_MAX, 32'd5);
		// Oversized rate and burst saturate; upper data bits ignored
		add_write(REG_BURST, 64'hFFFF_FFFF);
		add_write(REG_RATE, TIME_MAX);
		add_request(64'd0, 32'd1000000, 1'b1, 1'b1, 64'd0);
		add_request(64'd101, 32'd1);
		// Start at the top of time
		add_write(REG_RATE, 64'd1);
		add_write(REG_BURST, 64'd1);
		add_write(REG_START, TIME_MAX);
		add_request(TIME_MAX, 32'd1, 1'b1, 1'b1, 64'd0);
		add_request(64'd0, 32'd1, 1'b1, 1'b0, 64'd0);
		// Unused index: no reload
		add_write(REG_UNUSED, TIME_MAX);
		add_request(64'd5, 32'd0, 1'b1, 1'b1, 64'd0);
		add_write(REG_START, 64'd0);
		add_request(64'd500, 32'd1, 1'b1, 1'b1, 64'd0);
		add_request(64'd999, 32'd1);
		add_request(64'd1500, 32'd1);
		add_request(64'd2000, 32'd1);
		// Fill time rounds up
		add_write(REG_RATE, 64'd3);
		add_request(64'd0, 32'd1, 1'b1, 1'b1, 64'd0);
		add_request(64'd333, 32'd1);
		add_request(64'd334, 32'd1);
		// Zero rate with tokens in the bucket still denies
		add_write(REG_RATE, 64'd0);
		add_request(64'd400, 32'd1, 1'b1, 1'b0, 64'd1000000);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_request(script[i].now, script[i].cost, script[i].known, script[i].want);
				maybe_pause();
			end
		end

		// Random phases: new settings, then a run of requests
		while (random_sent < RANDOM_REQUESTS) begin
			mask  = 3'($urandom_range(1, 7));
			first = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) begin
				idx = CFG_IDX_W'((first + k) % 3);
				if (mask[idx]) begin
					case (idx)
						REG_START: begin
							case ($urandom_range(0, 3))
								0: dt = 64'($urandom_range(0, 1000));
								1: dt = {$urandom, $urandom};
								2: dt = TIME_MAX - 64'($urandom_range(0, 100000));
								default: dt = 64'd0;
							endcase
							write_reg(idx, dt);
						end
						default: write_reg(idx, pick_count_word());
					endcase
				end
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});

			// Keep always-deny phases short
			if (mdl_rate == 64'd0 || mdl_burst == 64'd0)
				phase_left = $urandom_range(5, 20);
			else
				phase_left = $urandom_range(40, 200);
			t_now = mdl_last;
			span  = (mdl_rate == 64'd0) ? 64'd1000 : (mdl_burst * MS_PER_S) / mdl_rate + 64'd1;

			while (phase_left > 0 && random_sent < RANDOM_REQUESTS) begin
				steady = (random_sent >= STEADY_FIRST && random_sent < STEADY_LAST);

				// Advance time mostly in steps near the fill time
				mode = $urandom_range(0, 99);
				if (mode < 65 || (mode >= 86 && mode < 96)) begin
					if (mode < 65)
						dt = 64'($urandom_range(0, 32'(span / 4 + 1)));
					else
						dt = 64'($urandom_range(0, 32'(span * 2)));
					t_now = (TIME_MAX - t_now < dt) ? TIME_MAX : t_now + dt;
					now   = t_now;
				end else if (mode < 78) begin
					now = t_now;
				end else if (mode < 86) begin
					dt  = 64'($urandom_range(1, 1000));
					now = (t_now < dt) ? 64'd0 : t_now - dt;
				end else begin
					now = {$urandom, $urandom};
					if (now > t_now && $urandom_range(0, 2) == 0)
						t_now = now;
				end

				mode = $urandom_range(0, 99);
				if (mode < 7)
					cost = '0;
				else if (mode < 50)
					cost = COST_W'($urandom_range(1, 3));
				else if (mode < 80)
					cost = COST_W'($urandom_range(1, 32'(mdl_burst / 4 + 1)));
				else if (mode < 93)
					cost = COST_W'($urandom_range(1, 32'(mdl_burst + 2)));
				else
					cost = COST_W'($urandom);

				send_request(now, cost, 1'b0, '0);
				random_sent++;
				phase_left--;
				maybe_pause();
			end
		end
		steady = 1'b0;

		// Let the last verdicts come back, then settle
		drain_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests in %0d cycles, %0d register writes, %0d verdicts checked",
			requests_sent, cycles, reg_writes, verdicts_seen);
		$display("%0d allowed, %0d denied, %0d mismatches", granted,
			verdicts_seen - granted, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
